// ===== hdl/nsd_pkg.sv =====
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and constants for the nearest segment distance block.
// ----------------------------------------------------------------------------
package nsd_pkg;

   localparam int MAX_SEGMENTS_DEF = 16;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = 17;            // difference of two Q8.8 coordinates
   localparam int OPR_W   = 19;            // shared multiplier operand width
   localparam int PROD_W  = 2 * OPR_W;     // shared multiplier product width
   localparam int ACC_W   = PROD_W + 1;    // sum of two products
   localparam int RAD_W   = 37;            // squared distance radicand
   localparam int T_W     = 17;            // Q1.16 projection parameter
   localparam int DIST_W  = 17;            // Q9.8 distance

   localparam logic [DIST_W-1:0] DIST_MAX       = 17'd92682;
   localparam logic [ACC_W-1:0]  ZERO_LEN_LIMIT = 39'd66;
   localparam logic [T_W-1:0]    T_ONE          = 17'h10000;
   localparam logic [RAD_W-1:0]  SQRT_BIT_INIT  = 37'h10_0000_0000;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_LEN_X,
      ST_LEN_Y,
      ST_DOT_X,
      ST_DOT_Y,
      ST_DECIDE,
      ST_DIV,
      ST_PROJ_X,
      ST_PROJ_Y,
      ST_RAD_X,
      ST_RAD_Y,
      ST_SQRT,
      ST_MIN,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/nearest_segment_distance_top.sv =====
// ----------------------------------------------------------------------------
// nearest_segment_distance_top
// Segment table with a serial point-to-segment minimum distance search.
// ----------------------------------------------------------------------------
// Append and remove words finish in the cycle they are accepted; req_ready
// stays high for the next word. A query walks the stored segments one at a
// time through a single shared 19x19 multiplier, a one-bit-per-cycle
// restoring divider and a two-bit-per-cycle square root. Each segment takes
// a table read, setup, multiplies and compares, a divide (skipped when t
// clamps or the segment is degenerate) and the root iteration; the divider
// and the root iteration bound the query time. While a query runs
// req_ready is low. The result sits in an output register, so the next
// word can be taken while it waits on rsp_ready. An empty table answers
// with the saturated maximum and rsp_table_empty set. Segment storage is a
// small register-file memory with a registered read port; entries hold
// nothing meaningful until appended, and none is cleared.
// ----------------------------------------------------------------------------
module nearest_segment_distance_top
   import nsd_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic signed [COORD_W-1:0] req_first_x,
   input  logic signed [COORD_W-1:0] req_first_y,
   input  logic signed [COORD_W-1:0] req_second_x,
   input  logic signed [COORD_W-1:0] req_second_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DIST_W-1:0]         rsp_min_distance,
   output logic                      rsp_table_empty
);

   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SEGMENTS);

   // segment memory, registered read
   logic signed [COORD_W-1:0] mem_sx [MAX_SEGMENTS];
   logic signed [COORD_W-1:0] mem_sy [MAX_SEGMENTS];
   logic signed [COORD_W-1:0] mem_ex [MAX_SEGMENTS];
   logic signed [COORD_W-1:0] mem_ey [MAX_SEGMENTS];
   logic signed [COORD_W-1:0] rd_sx_ff, rd_sy_ff, rd_ex_ff, rd_ey_ff;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [DIFF_W-1:0]  dx_ff, dx_in, dy_ff, dy_in, rx_ff, rx_in, ry_ff, ry_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   sq_ff, sq_in;
   logic signed [ACC_W-1:0]   dot_ff, dot_in;
   logic signed [ACC_W-1:0]   rem_ff, rem_in;
   logic [3:0]                dcnt_ff, dcnt_in;
   logic [T_W-1:0]            t_ff, t_in;
   logic signed [OPR_W-1:0]   qx_ff, qx_in, qy_ff, qy_in;
   logic [RAD_W-1:0]          rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic [DIST_W-1:0]         best_ff, best_in;
   logic                      empty_ff, empty_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_empty_ff, rsp_empty_in;

   // shared multiplier
   logic signed [OPR_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [ACC_W-1:0]  mul_pe;

   logic                    req_fire;
   logic                    out_free;
   logic                    last_seg;
   logic signed [ACC_W-1:0] rem_dbl;
   logic                    div_bit;
   logic [RAD_W-1:0]        root_try;
   logic                    sqrt_take;
   logic [RAD_W-1:0]        dist_full;
   logic [DIST_W-1:0]       dist_clamp;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_seg  = ((idx_ff + CNT_W'(1)) == count_ff);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_distance = rsp_dist_ff;
   assign rsp_table_empty  = rsp_empty_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LEN_X: begin
            mul_a = OPR_W'(dx_ff);
            mul_b = OPR_W'(dx_ff);
         end
         ST_LEN_Y: begin
            mul_a = OPR_W'(dy_ff);
            mul_b = OPR_W'(dy_ff);
         end
         ST_DOT_X: begin
            mul_a = OPR_W'(rx_ff);
            mul_b = OPR_W'(dx_ff);
         end
         ST_DOT_Y: begin
            mul_a = OPR_W'(ry_ff);
            mul_b = OPR_W'(dy_ff);
         end
         ST_PROJ_X: begin
            mul_a = $signed({2'b00, t_ff});
            mul_b = OPR_W'(dx_ff);
         end
         ST_PROJ_Y: begin
            mul_a = $signed({2'b00, t_ff});
            mul_b = OPR_W'(dy_ff);
         end
         ST_RAD_X: begin
            mul_a = qx_ff;
            mul_b = qx_ff;
         end
         ST_RAD_Y: begin
            mul_a = qy_ff;
            mul_b = qy_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign mul_pe = ACC_W'(mul_p);

   // restoring divider step: one quotient bit per cycle
   assign rem_dbl = rem_ff <<< 1;
   assign div_bit = (rem_dbl >= sq_ff);

   // square root step: two radicand bits per cycle
   assign root_try  = root_ff + bit_ff;
   assign sqrt_take = (rad_ff >= root_try);

   assign dist_full  = root_ff;
   assign dist_clamp = (dist_full > RAD_W'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == KIND_QUERY)) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_READ;
            end
         end
         ST_READ:   state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_LEN_X;
         ST_LEN_X:  state_in = ST_LEN_Y;
         ST_LEN_Y:  state_in = ST_DOT_X;
         ST_DOT_X:  state_in = ST_DOT_Y;
         ST_DOT_Y:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (sq_ff < ZERO_LEN_LIMIT) begin
               state_in = ST_RAD_X;
            end else if ((dot_ff <= 0) || (dot_ff >= sq_ff)) begin
               state_in = ST_PROJ_X;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dcnt_ff == 4'd15) begin
               state_in = ST_PROJ_X;
            end
         end
         ST_PROJ_X: state_in = ST_PROJ_Y;
         ST_PROJ_Y: state_in = ST_RAD_X;
         ST_RAD_X:  state_in = ST_RAD_Y;
         ST_RAD_Y:  state_in = ST_SQRT;
         ST_SQRT: begin
            if (bit_ff[0]) begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            state_in = last_seg ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      dot_in       = dot_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      t_in         = t_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      best_in      = best_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_empty_in = rsp_empty_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_APPEND: begin
                     if (count_ff < CNT_FULL) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_REMOVE: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  KIND_QUERY: begin
                     px_in    = req_first_x;
                     py_in    = req_first_y;
                     idx_in   = '0;
                     best_in  = DIST_MAX;
                     empty_in = (count_ff == '0);
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_DIFF: begin
            dx_in = DIFF_W'(rd_ex_ff) - DIFF_W'(rd_sx_ff);
            dy_in = DIFF_W'(rd_ey_ff) - DIFF_W'(rd_sy_ff);
            rx_in = DIFF_W'(px_ff) - DIFF_W'(rd_sx_ff);
            ry_in = DIFF_W'(py_ff) - DIFF_W'(rd_sy_ff);
         end
         ST_LEN_X: acc_in = mul_pe;
         ST_LEN_Y: sq_in  = acc_ff + mul_pe;
         ST_DOT_X: acc_in = mul_pe;
         ST_DOT_Y: dot_in = acc_ff + mul_pe;
         ST_DECIDE: begin
            qx_in   = OPR_W'(rx_ff);
            qy_in   = OPR_W'(ry_ff);
            rem_in  = dot_ff;
            dcnt_in = '0;
            if (dot_ff <= 0) begin
               t_in = '0;
            end else if (dot_ff >= sq_ff) begin
               t_in = T_ONE;
            end else begin
               t_in = '0;
            end
         end
         ST_DIV: begin
            rem_in  = div_bit ? (rem_dbl - sq_ff) : rem_dbl;
            t_in    = {t_ff[T_W-2:0], div_bit};
            dcnt_in = dcnt_ff + 4'd1;
         end
         ST_PROJ_X: begin
            // floor of t*dx in Q8.8 by arithmetic shift
            qx_in = OPR_W'(rx_ff) - OPR_W'(mul_p >>> 16);
         end
         ST_PROJ_Y: begin
            qy_in = OPR_W'(ry_ff) - OPR_W'(mul_p >>> 16);
         end
         ST_RAD_X: acc_in = mul_pe;
         ST_RAD_Y: begin
            rad_in  = RAD_W'(acc_ff + mul_pe);
            root_in = '0;
            bit_in  = SQRT_BIT_INIT;
         end
         ST_SQRT: begin
            if (sqrt_take) begin
               rad_in  = rad_ff - root_try;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         ST_MIN: begin
            if (dist_clamp < best_ff) begin
               best_in = dist_clamp;
            end
            idx_in = idx_ff + CNT_W'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = best_ff;
               rsp_empty_in = empty_ff;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // segment memory
   always_ff @(posedge clock) begin
      if (req_fire && (req_kind == KIND_APPEND) && (count_ff < CNT_FULL)) begin
         mem_sx[count_ff[IDX_W-1:0]] <= req_first_x;
         mem_sy[count_ff[IDX_W-1:0]] <= req_first_y;
         mem_ex[count_ff[IDX_W-1:0]] <= req_second_x;
         mem_ey[count_ff[IDX_W-1:0]] <= req_second_y;
      end
      rd_sx_ff <= mem_sx[idx_ff[IDX_W-1:0]];
      rd_sy_ff <= mem_sy[idx_ff[IDX_W-1:0]];
      rd_ex_ff <= mem_ex[idx_ff[IDX_W-1:0]];
      rd_ey_ff <= mem_ey[idx_ff[IDX_W-1:0]];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      acc_ff       <= acc_in;
      sq_ff        <= sq_in;
      dot_ff       <= dot_in;
      rem_ff       <= rem_in;
      t_ff         <= t_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      best_ff      <= best_in;
      empty_ff     <= empty_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_empty_ff <= rsp_empty_in;
   end

endmodule

// ===== hdl/nsd_checker.sv =====
// ----------------------------------------------------------------------------
// nsd_checker
// Port-level checks for the nearest segment distance block.
// ----------------------------------------------------------------------------
module nsd_checker
   import nsd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_kind,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DIST_W-1:0] rsp_min_distance,
   input logic              rsp_table_empty
);

   // an empty table always reports the saturated maximum
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_empty) |-> (rsp_min_distance == DIST_MAX))
      else $error("empty table word without saturated distance");

   // distance never exceeds the clamp
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_distance <= DIST_MAX))
      else $error("distance above clamp");

   // a query holds off new words while it runs
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_QUERY)) |=> !req_ready)
      else $error("ready during query");

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_min_distance) && $stable(rsp_table_empty)))
      else $error("stalled result word changed");

endmodule

bind nearest_segment_distance_top nsd_checker u_nsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_kind         (req_kind),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_min_distance (rsp_min_distance),
   .rsp_table_empty  (rsp_table_empty)
);
